### design/itx_pkg.sv
// Shared constants, types and helpers for the radix text converter.
package itx_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;
  localparam int BIT_W       = $clog2(VALUE_WIDTH);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

  localparam logic [BASE_W-1:0]  BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0]  BASE_DEC   = BASE_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0]  CHAR_NONE  = CHAR_W'(0);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(87);  // 'a' minus ten
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INV,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_EMIT
  } itx_state_t;

  // Map a digit value 0..35 to '0'-'9' then 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_ALPHA + ext;
    end
  endfunction

endpackage

### design/itx_in_if.sv
// Input channel: value, signed mode and base with valid/ready.
interface itx_in_if;
  logic                                valid;
  logic                                ready;
  logic [itx_pkg::VALUE_WIDTH-1:0]     value;
  logic                                signed_mode;
  logic [itx_pkg::BASE_W-1:0]          base;

  modport source (output valid, output value, output signed_mode, output base, input ready);
  modport sink   (input valid, input value, input signed_mode, input base, output ready);
endinterface

### design/itx_out_if.sv
// Result channel: one character per transfer with last and invalid flags.
interface itx_out_if;
  logic                          valid;
  logic                          ready;
  logic [itx_pkg::CHAR_W-1:0]    character;
  logic                          last;
  logic                          invalid;

  modport source (output valid, output character, output last, output invalid, input ready);
  modport sink   (input valid, input character, input last, input invalid, output ready);
endinterface

### design/integer_to_radix_text.sv
// Top level: bit-serial integer to radix text converter (bases 2 to 36).
//
//   Channel   Direction  Carries                          Handshake
//   in_ch     sink       value, signed_mode, base         valid/ready
//   out_ch    source     character, last, invalid         valid/ready
//
// Each digit is a full pass of the one-bit-per-cycle restoring divider over
// all VALUE_WIDTH (32) quotient bits; each character is then a digit buffer
// read followed by an output load.
// Reset is synchronous, active low, and clears control state only.
// A stalled result holds in the output register; the sequencer waits for it.
module integer_to_radix_text (
  input  logic      clk,
  input  logic      rst_n,
  itx_in_if.sink    in_ch,
  itx_out_if.source out_ch
);

  localparam int VW = itx_pkg::VALUE_WIDTH;

  itx_pkg::itx_state_t state_r, state_nxt;

  // Divider and sequencing registers
  logic [VW-1:0]                   quo_r;
  logic [itx_pkg::DIGIT_W-1:0]     rem_r;
  logic [itx_pkg::BASE_W-1:0]      base_r;
  logic                            neg_r;
  logic [itx_pkg::BIT_W-1:0]       bit_r;
  logic [itx_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [itx_pkg::DIGIT_W-1:0]     rd_data_r;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [itx_pkg::CHAR_W-1:0]      out_char_r;
  logic                            out_last_r;
  logic                            out_inv_r;

  // Digit buffer, least significant digit first
  logic [itx_pkg::DIGIT_W-1:0]     digit_mem [itx_pkg::MAX_DIGITS];

  // Input decode
  logic                            in_xfer;
  logic                            base_ok;
  logic                            in_neg;
  logic [VW-1:0]                   in_mag;

  // Divider step
  logic [itx_pkg::DIGIT_W:0]       trial;
  logic [itx_pkg::DIGIT_W:0]       diff;
  logic                            ge;
  logic [itx_pkg::DIGIT_W-1:0]     rem_step;
  logic [VW-1:0]                   quo_step;
  logic                            bit_last;
  logic [itx_pkg::CNT_W-1:0]       cnt_inc;
  logic [itx_pkg::CNT_W-1:0]       limit;
  logic                            div_done;

  // Control outputs
  logic                            slot_free;
  logic                            ld_inv, ld_sign, ld_dig;
  logic                            wr_en, rd_en;
  logic [itx_pkg::ADDR_W-1:0]      rd_addr;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign base_ok = (in_ch.base >= itx_pkg::BASE_MIN) && (in_ch.base <= itx_pkg::BASE_MAX);
  assign in_neg  = in_ch.signed_mode && (in_ch.base == itx_pkg::BASE_DEC) && in_ch.value[VW-1];
  assign in_mag  = in_neg ? (~in_ch.value + VW'(1)) : in_ch.value;

  // Restoring division: bring down one quotient bit per cycle
  assign trial    = {rem_r, quo_r[VW-1]};
  assign diff     = trial - {1'b0, base_r};
  assign ge       = trial >= {1'b0, base_r};
  assign rem_step = ge ? diff[itx_pkg::DIGIT_W-1:0] : trial[itx_pkg::DIGIT_W-1:0];
  assign quo_step = {quo_r[VW-2:0], ge};
  assign bit_last = bit_r == itx_pkg::BIT_W'(VW - 1);
  assign cnt_inc  = cnt_r + itx_pkg::CNT_W'(1);
  assign limit    = neg_r ? itx_pkg::CNT_W'(itx_pkg::MAX_DIGITS - 1)
                          : itx_pkg::CNT_W'(itx_pkg::MAX_DIGITS);
  assign div_done = (quo_step == '0) || (cnt_inc == limit);

  assign slot_free = !out_valid_r || out_ch.ready;
  assign rd_addr   = itx_pkg::ADDR_W'(cnt_r - itx_pkg::CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itx_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = base_ok ? itx_pkg::ST_DIV : itx_pkg::ST_INV;
        end
      end
      itx_pkg::ST_INV: begin
        if (slot_free) begin
          state_nxt = itx_pkg::ST_IDLE;
        end
      end
      itx_pkg::ST_DIV: begin
        if (bit_last && div_done) begin
          state_nxt = neg_r ? itx_pkg::ST_SIGN : itx_pkg::ST_RD;
        end
      end
      itx_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_nxt = itx_pkg::ST_RD;
        end
      end
      itx_pkg::ST_RD: begin
        state_nxt = itx_pkg::ST_EMIT;
      end
      itx_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = (cnt_r == itx_pkg::CNT_W'(1)) ? itx_pkg::ST_IDLE : itx_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = itx_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs; hold off input transfers while reset is asserted
  always_comb begin
    in_ch.ready = 1'b0;
    ld_inv      = 1'b0;
    ld_sign     = 1'b0;
    ld_dig      = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    unique case (state_r)
      itx_pkg::ST_IDLE: in_ch.ready = rst_n;
      itx_pkg::ST_INV:  ld_inv      = slot_free;
      itx_pkg::ST_DIV:  wr_en       = bit_last;
      itx_pkg::ST_SIGN: ld_sign     = slot_free;
      itx_pkg::ST_RD:   rd_en       = 1'b1;
      itx_pkg::ST_EMIT: ld_dig      = slot_free;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Digit count: restart on a transfer, advance per stored digit, drop per character
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      cnt_nxt = '0;
    end else if (wr_en) begin
      cnt_nxt = cnt_inc;
    end else if (ld_dig) begin
      cnt_nxt = cnt_r - itx_pkg::CNT_W'(1);
    end
  end

  // Output valid: set on load, clear on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_inv || ld_sign || ld_dig) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itx_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Divider datapath: load on transfer, step while dividing
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      quo_r  <= in_mag;
      rem_r  <= '0;
      bit_r  <= '0;
      base_r <= in_ch.base;
      neg_r  <= in_neg;
    end else if (state_r == itx_pkg::ST_DIV) begin
      quo_r <= quo_step;
      rem_r <= bit_last ? '0 : rem_step;
      bit_r <= bit_last ? '0 : bit_r + itx_pkg::BIT_W'(1);
    end
  end

  // Digit buffer: write the finished remainder, read with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt_r[itx_pkg::ADDR_W-1:0]] <= rem_step;
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[rd_addr];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ld_inv) begin
      out_char_r <= itx_pkg::CHAR_NONE;
      out_last_r <= 1'b1;
      out_inv_r  <= 1'b1;
    end else if (ld_sign) begin
      out_char_r <= itx_pkg::CHAR_MINUS;
      out_last_r <= 1'b0;
      out_inv_r  <= 1'b0;
    end else if (ld_dig) begin
      out_char_r <= itx_pkg::digit_char(rd_data_r);
      out_last_r <= cnt_r == itx_pkg::CNT_W'(1);
      out_inv_r  <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.invalid   = out_inv_r;

  // The partial remainder never reaches the base while dividing
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itx_pkg::ST_DIV) |-> (rem_r < base_r))
    else $error("remainder reached base");

  // Characters are only read back while digits remain in the buffer
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itx_pkg::ST_RD || state_r == itx_pkg::ST_EMIT) |-> (cnt_r != '0))
    else $error("digit buffer read with no digits left");

  // An invalid result is a lone terminating null character
  a_inv_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_last_r && out_char_r == itx_pkg::CHAR_NONE))
    else $error("malformed invalid result");

  // A digit load following a read of the last digit ends the conversion
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_dig && cnt_r == itx_pkg::CNT_W'(1)) |=> (state_r == itx_pkg::ST_IDLE && out_last_r))
    else $error("final character did not end the conversion");

endmodule

### tb/sv/tb_top.sv
// Testbench for the radix text converter: directed and random conversions, checked per character.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 12000;
  localparam int SETTLE_TICKS = 200;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_EVERY  = 90;

  typedef struct packed {
    logic [itx_pkg::CHAR_W-1:0] character;
    logic                       last;
    logic                       invalid;
  } text_char_t;

  // Receiver stall styles, switched at random whenever ready_phase[6:0] is zero.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_BLOCKED
  } rx_style_t;

  logic clk = 1'b0;
  logic rst_n;

  itx_in_if  in_bus ();
  itx_out_if out_bus ();

  integer_to_radix_text i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  text_char_t  expected_text[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          burst_left   = 0;
  bit          holding_valid = 1'b0;
  logic [7:0]  ready_phase  = '0;
  rx_style_t   rx_style     = RX_OPEN;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (at %0t)", field, got, want, $realtime);
    mismatches++;
  endtask

  // Work out the characters one conversion must produce and queue them.
  function automatic void predict_text(input logic [itx_pkg::VALUE_WIDTH-1:0] value,
                                       input logic                            signed_mode,
                                       input logic [itx_pkg::BASE_W-1:0]      base);
    logic [itx_pkg::VALUE_WIDTH-1:0] magnitude;
    logic [itx_pkg::DIGIT_W-1:0]     digits[$];
    logic                            negative;
    int                              limit;
    text_char_t                      ch;
    string                           glyphs;
    glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
    ch.invalid = 1'b0;
    if (base < itx_pkg::BASE_MIN || base > itx_pkg::BASE_MAX) begin
      ch.character = itx_pkg::CHAR_NONE;
      ch.last      = 1'b1;
      ch.invalid   = 1'b1;
      expected_text.push_back(ch);
      return;
    end
    // Only signed decimal gets a minus sign; the most negative value wraps to 2^31.
    negative  = signed_mode && (base == itx_pkg::BASE_DEC) && value[itx_pkg::VALUE_WIDTH-1];
    magnitude = negative ? (~value + 1'b1) : value;
    limit     = negative ? itx_pkg::MAX_DIGITS - 1 : itx_pkg::MAX_DIGITS;
    do begin
      digits.push_back(itx_pkg::DIGIT_W'(magnitude % base));
      magnitude = magnitude / base;
    end while (magnitude != 0 && digits.size() < limit);
    if (negative) begin
      ch.character = itx_pkg::CHAR_MINUS;
      ch.last      = 1'b0;
      expected_text.push_back(ch);
    end
    // Emit most significant digit first.
    for (int k = digits.size() - 1; k >= 0; k--) begin
      ch.character = itx_pkg::CHAR_W'(glyphs[digits[k]]);
      ch.last      = (k == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // Send one conversion request; bursts of back-to-back transfers with idle gaps between.
  task automatic send_item(input logic [itx_pkg::VALUE_WIDTH-1:0] value,
                           input logic signed_mode,
                           input logic [itx_pkg::BASE_W-1:0] base);
    int gap;
    if (burst_left == 0) begin
      if (holding_valid) begin
        in_bus.valid <= 1'b0;
        holding_valid = 1'b0;
      end
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_bus.valid       <= 1'b1;
    in_bus.value       <= value;
    in_bus.signed_mode <= signed_mode;
    in_bus.base        <= base;
    holding_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!(in_bus.valid && in_bus.ready));
    predict_text(value, signed_mode, base);
    burst_left--;
  endtask

  // Hold off the sender until every queued character has arrived.
  task automatic wait_drained();
    if (holding_valid) begin
      in_bus.valid <= 1'b0;
      holding_valid = 1'b0;
    end
    burst_left = 0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero();
    send_item('0, 1'b0, 6'd2);
    send_item('0, 1'b1, itx_pkg::BASE_DEC);
    send_item('0, 1'b0, itx_pkg::BASE_MAX);
  endtask

  // Full-width patterns, the longest text and the highest digit.
  task automatic test_extremes();
    send_item('1, 1'b0, itx_pkg::BASE_MIN);
    send_item('1, 1'b0, itx_pkg::BASE_DEC);
    send_item('1, 1'b0, 6'd16);
    send_item('1, 1'b0, itx_pkg::BASE_MAX);
    send_item('1, 1'b1, 6'd16);
    send_item(32'h7FFF_FFFF, 1'b1, itx_pkg::BASE_DEC);
    send_item(32'd1, 1'b0, itx_pkg::BASE_MIN);
    send_item(32'd35, 1'b0, itx_pkg::BASE_MAX);
    send_item(32'd36, 1'b1, itx_pkg::BASE_MAX);
  endtask

  // Minus sign only in signed decimal; the most negative value must not overflow.
  task automatic test_signed_decimal();
    send_item(32'h8000_0000, 1'b1, itx_pkg::BASE_DEC);
    send_item(32'hFFFF_FFFF, 1'b1, itx_pkg::BASE_DEC);
    send_item(32'h8000_0000, 1'b0, itx_pkg::BASE_DEC);
    send_item(32'hC000_0000, 1'b1, 6'd8);
    wait_drained();
  endtask

  task automatic test_invalid_base();
    send_item(32'd123, 1'b0, 6'd0);
    send_item(32'hFFFF_FFFF, 1'b1, 6'd1);
    send_item(32'h8000_0000, 1'b1, 6'd37);
    send_item(32'h1234_5678, 1'b0, 6'd63);
  endtask

  // Random values and bases, weighted toward digit-count boundaries and signed decimal.
  task automatic test_random_mix();
    logic [itx_pkg::VALUE_WIDTH-1:0] value;
    logic [itx_pkg::BASE_W-1:0]      base;
    longint unsigned                 power;
    int                              pick;
    int                              steps;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        base = itx_pkg::BASE_W'($urandom_range(0, 28));
        if (base >= 2) base = base + 6'd35;
      end else if (pick < 7) begin
        base = itx_pkg::BASE_DEC;
      end else begin
        base = itx_pkg::BASE_W'($urandom_range(2, 36));
      end
      pick = $urandom_range(0, 9);
      case (pick) inside
        [0:3]: value = $urandom();
        [4:5]: value = $urandom_range(0, 999);
        6: begin
          // land on or just below a power of the base
          power = 1;
          steps = $urandom_range(1, 32);
          for (int i = 0; i < steps; i++) begin
            if (base >= 2 && power * base <= 64'hFFFF_FFFF) power = power * base;
          end
          value = itx_pkg::VALUE_WIDTH'(power - $urandom_range(0, 1));
        end
        7: value = {1'b1, 31'($urandom())};
        8: begin
          case ($urandom_range(0, 3))
            0:       value = '0;
            1:       value = '1;
            2:       value = 32'h8000_0000;
            default: value = 32'h7FFF_FFFF;
          endcase
        end
        default: value = $urandom() & $urandom();
      endcase
      send_item(value, 1'($urandom_range(0, 1)), base);
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
    end
  endtask

  // Compare each accepted character against the oldest expectation.
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected character", 32'(out_bus.character), 0);
      end else begin
        want = expected_text.pop_front();
        if (out_bus.character !== want.character)
          report_mismatch("character", 32'(out_bus.character), 32'(want.character));
        if (out_bus.last !== want.last)
          report_mismatch("last", 32'(out_bus.last), 32'(want.last));
        if (out_bus.invalid !== want.invalid)
          report_mismatch("invalid", 32'(out_bus.invalid), 32'(want.invalid));
      end
    end
  end

  // Receiver backpressure: open, random, sparse or blocked stretches.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase[6:0] == '0) rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:   out_bus.ready <= 1'b1;
      RX_RANDOM: out_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_bus.ready <= (ready_phase[1:0] == 2'd0);
      default:   out_bus.ready <= (ready_phase[4:3] != 2'd0);
    endcase
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("integer_to_radix_text regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.value       = '0;
    in_bus.signed_mode = 1'b0;
    in_bus.base        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_zero();
    test_extremes();
    test_signed_decimal();
    test_invalid_base();
    test_random_mix();

    // Let everything drain, then watch for stray characters.
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("integer_to_radix_text regression: pass");
    end else begin
      $display("integer_to_radix_text regression: fail");
    end
    $finish;
  end

endmodule
